// ===== sv/phga_pkg.sv =====
// ----------------------------------------------------------------------------
// phga_pkg
// Shared constants, types and the heat-to-color table for the heat grid
// animator.
// ----------------------------------------------------------------------------
package phga_pkg;

	// Grid geometry: both sides are powers of two, so coordinates pack into
	// one address and the random pick is a bit mask.
	localparam int COL_BITS    = 6;
	localparam int ROW_BITS    = 6;
	localparam int GRID_WIDTH  = 1 << COL_BITS;
	localparam int GRID_HEIGHT = 1 << ROW_BITS;
	localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_BITS   = COL_BITS + ROW_BITS;

	localparam logic [31:0] RNG_RESET = 32'h1234ABCD;
	localparam logic [31:0] SEED_MASK = 32'hDEADBEEF;

	// Operation codes carried in s_tuser
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_IGNITION_TIME = 3'd0;
	localparam logic [2:0] REG_TOTAL_TIME    = 3'd1;
	localparam logic [2:0] REG_SPARKS        = 3'd2;
	localparam logic [2:0] REG_SPREAD_MIN    = 3'd3;
	localparam logic [2:0] REG_SPREAD_HEAT   = 3'd4;
	localparam logic [2:0] REG_HEAT_INC      = 3'd5;

	// Color table entry {blue, green, red}
	typedef logic [23:0] shade_lut_t [256];

	// Piecewise red-orange-yellow-white ramp, evaluated at elaboration only
	function automatic shade_lut_t build_shade();
		shade_lut_t lut;
		int r;
		int g;
		int b;
		for (int h = 0; h < 256; h++) begin
			r = 0;
			g = 0;
			b = 0;
			if (h == 0) begin
				r = 0;
			end else if (h < 50) begin
				r = (h * 80) / 50;
			end else if (h < 130) begin
				r = 80 + ((h - 50) * 175) / 80;
			end else if (h < 190) begin
				r = 255;
				g = ((h - 130) * 140) / 60;
			end else if (h < 230) begin
				r = 255;
				g = 140 + ((h - 190) * 115) / 40;
			end else begin
				r = 255;
				g = 255;
				b = ((h - 230) * 255) / 25;
				if (b > 255) begin
					b = 255;
				end
			end
			lut[h] = {b[7:0], g[7:0], r[7:0]};
		end
		return lut;
	endfunction

	localparam shade_lut_t SHADE_LUT = build_shade();

endpackage

// ===== sv/phosphor_heat_grid_animator.sv =====
// ----------------------------------------------------------------------------
// phosphor_heat_grid_animator
// Heat grid with spread, random sparks and saturating heating per tick,
// plus pixel read-out with a heat-to-color ramp.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tuser: operation; tdata: seed, elapsed,
//                                     column, row
//  m_*      out  m_tvalid / m_tready  tdata: red, green, blue, heat, finished
//  apb      in   psel/penable/pready  six registers at 4*index
//
//  After reset the grid is cleared, one cell per cycle, with s_tready low. A
//  start item clears the same way and then returns a result. A tick runs the
//  spread sweep over every cell, the sparks (while elapsed is below the
//  ignition time) and the heat sweep over every cell, all through the single
//  grid RAM port. A read returns the cell's heat and color; a tick at or past
//  the total time skips the sweeps. One item at a time; the result register lets the next item in
//  while a result still waits on m_tready.
// ----------------------------------------------------------------------------
module phosphor_heat_grid_animator (
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] seed_value, [47:32] elapsed_ms,
	                               // [53:48] pixel_column, [59:54] pixel_row
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// result item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] color_red, [15:8] color_green,
	                               // [23:16] color_blue, [31:24] pixel_heat,
	                               // [32] finished
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = phga_pkg::ADDR_BITS;
	localparam int CW = phga_pkg::COL_BITS;
	localparam int RW = phga_pkg::ROW_BITS;
	localparam logic [AW-1:0] LAST_CELL = AW'(phga_pkg::GRID_CELLS - 1);
	localparam logic [CW-1:0] LAST_COL  = CW'(phga_pkg::GRID_WIDTH - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(phga_pkg::GRID_HEIGHT - 1);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_SP_RD, ST_SP_CK, ST_SP_WR,
		ST_SK_X, ST_SK_Y, ST_SK_RD, ST_SK_CK,
		ST_HT_RD, ST_HT_CK, ST_RD_RD, ST_RD_CK, ST_FIN
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  pix_q;
	logic [2:0]     nb_q;
	logic [7:0]     max_q;
	logic           hot_q;
	logic [3:0]     cnt_q;
	logic [31:0]    rng_q;
	logic [CW-1:0]  sx_q;
	logic [15:0]    elapsed_q;
	logic           clr_reply_q;
	logic [32:0]    res_q;
	logic           m_tvalid_q;
	logic [39:0]    m_tdata_q;

	logic [15:0] ignition_q;
	logic [15:0] total_q;
	logic [3:0]  sparks_q;
	logic [7:0]  spread_min_q;
	logic [7:0]  spread_heat_q;
	logic [7:0]  heat_inc_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// input fields
	logic [1:0]    in_op;
	logic [31:0]   in_seed;
	logic [15:0]   in_elapsed;
	logic [CW-1:0] in_col;
	logic [RW-1:0] in_row;

	assign in_op      = s_tuser;
	assign in_seed    = s_tdata[31:0];
	assign in_elapsed = s_tdata[47:32];
	assign in_col     = s_tdata[48 +: CW];
	assign in_row     = s_tdata[54 +: RW];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;

	// xorshift generator step: left 13, right 17, left 5
	function automatic logic [31:0] xorshift(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	// Neighbor address of the current cell; nb 1..4 = left, right, up, down
	logic [CW-1:0] cur_col;
	logic [RW-1:0] cur_row;
	logic [AW-1:0] nb_addr;
	logic          nb_ok;

	assign cur_col = pix_q[CW-1:0];
	assign cur_row = pix_q[AW-1:CW];

	always_comb begin
		nb_addr = pix_q;
		nb_ok   = 1'b1;
		case (nb_q)
			3'd1: begin
				nb_addr = pix_q - AW'(1);
				nb_ok   = (cur_col != '0);
			end
			3'd2: begin
				nb_addr = pix_q + AW'(1);
				nb_ok   = (cur_col != LAST_COL);
			end
			3'd3: begin
				nb_addr = pix_q - AW'(phga_pkg::GRID_WIDTH);
				nb_ok   = (cur_row != '0);
			end
			3'd4: begin
				nb_addr = pix_q + AW'(phga_pkg::GRID_WIDTH);
				nb_ok   = (cur_row != LAST_ROW);
			end
			default: begin
				nb_addr = pix_q;
				nb_ok   = 1'b1;
			end
		endcase
	end

	// Running neighbor maximum and saturating adds
	logic [7:0] nb_max;
	logic [8:0] heat_sum;
	logic [7:0] heat_sat;
	logic [8:0] spark_sum;
	logic [7:0] spark_heat;
	logic       sparks_on;

	assign nb_max     = (ram_rdata > max_q) ? ram_rdata : max_q;
	assign heat_sum   = {1'b0, ram_rdata} + {1'b0, heat_inc_q};
	assign heat_sat   = heat_sum[8] ? 8'hFF : heat_sum[7:0];
	assign spark_sum  = {1'b0, spread_min_q} + 9'd1;
	assign spark_heat = spark_sum[8] ? 8'hFF : spark_sum[7:0];
	assign sparks_on  = (elapsed_q < ignition_q) && (sparks_q != '0);

	// Grid RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pix_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_SP_RD: begin
				ram_addr = nb_addr;
			end
			ST_SP_WR: begin
				// only a cold cell catches from its neighbors
				ram_we    = !hot_q && (max_q >= spread_min_q);
				ram_wdata = spread_heat_q;
			end
			ST_SK_RD: begin
				ram_addr = pix_q;
			end
			ST_SK_CK: begin
				ram_we    = (ram_rdata == '0);
				ram_wdata = spark_heat;
			end
			ST_HT_CK: begin
				ram_we    = (ram_rdata != '0);
				ram_wdata = heat_sat;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	phga_ram #(
		.WIDTH(8),
		.DEPTH(phga_pkg::GRID_CELLS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sequencer, result register and generator
	logic [23:0] shade;
	logic [31:0] rng_adv;
	logic        res_load;

	assign shade    = phga_pkg::SHADE_LUT[ram_rdata];
	assign rng_adv  = xorshift(rng_q);
	assign res_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			pix_q       <= '0;
			nb_q        <= '0;
			cnt_q       <= '0;
			rng_q       <= phga_pkg::RNG_RESET;
			clr_reply_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					pix_q <= pix_q + AW'(1);
					if (pix_q == LAST_CELL) begin
						state_q <= clr_reply_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						res_q     <= {(in_op == phga_pkg::OP_TICK) && (in_elapsed >= total_q),
						              32'd0};
						elapsed_q <= in_elapsed;
						pix_q     <= (in_op == phga_pkg::OP_READ) ? {in_row, in_col} : '0;
						nb_q      <= '0;
						case (in_op)
							phga_pkg::OP_START: begin
								rng_q       <= in_seed ^ phga_pkg::SEED_MASK;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLR;
							end
							phga_pkg::OP_TICK: begin
								if (in_elapsed >= total_q) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_SP_RD;
								end
							end
							phga_pkg::OP_READ: begin
								state_q <= ST_RD_RD;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SP_RD: begin
					if (nb_ok) begin
						state_q <= ST_SP_CK;
					end else if (nb_q == 3'd4) begin
						state_q <= ST_SP_WR;
					end else begin
						nb_q <= nb_q + 3'd1;
					end
				end
				ST_SP_CK: begin
					if (nb_q == 3'd0) begin
						max_q <= '0;
						hot_q <= (ram_rdata != '0);
						if (ram_rdata != '0) begin
							state_q <= ST_SP_WR;
						end else begin
							nb_q    <= 3'd1;
							state_q <= ST_SP_RD;
						end
					end else begin
						max_q <= nb_max;
						if (nb_q == 3'd4) begin
							state_q <= ST_SP_WR;
						end else begin
							nb_q    <= nb_q + 3'd1;
							state_q <= ST_SP_RD;
						end
					end
				end
				ST_SP_WR: begin
					nb_q <= '0;
					if (pix_q == LAST_CELL) begin
						pix_q   <= '0;
						cnt_q   <= sparks_q;
						state_q <= sparks_on ? ST_SK_X : ST_HT_RD;
					end else begin
						pix_q   <= pix_q + AW'(1);
						state_q <= ST_SP_RD;
					end
				end
				ST_SK_X: begin
					rng_q   <= rng_adv;
					sx_q    <= rng_adv[CW-1:0];
					state_q <= ST_SK_Y;
				end
				ST_SK_Y: begin
					rng_q   <= rng_adv;
					pix_q   <= {rng_adv[RW-1:0], sx_q};
					state_q <= ST_SK_RD;
				end
				ST_SK_RD: begin
					state_q <= ST_SK_CK;
				end
				ST_SK_CK: begin
					if (cnt_q == 4'd1) begin
						pix_q   <= '0;
						state_q <= ST_HT_RD;
					end else begin
						cnt_q   <= cnt_q - 4'd1;
						state_q <= ST_SK_X;
					end
				end
				ST_HT_RD: begin
					state_q <= ST_HT_CK;
				end
				ST_HT_CK: begin
					if (pix_q == LAST_CELL) begin
						state_q <= ST_FIN;
					end else begin
						pix_q   <= pix_q + AW'(1);
						state_q <= ST_HT_RD;
					end
				end
				ST_RD_RD: begin
					state_q <= ST_RD_CK;
				end
				ST_RD_CK: begin
					res_q   <= {1'b0, ram_rdata, shade[23:16], shade[15:8], shade[7:0]};
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_load) begin
						m_tdata_q   <= {7'd0, res_q};
						clr_reply_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers
	logic [2:0] reg_idx;
	logic       cfg_wr;

	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignition_q    <= 16'd1800;
			total_q       <= 16'd3200;
			sparks_q      <= 4'd5;
			spread_min_q  <= 8'd8;
			spread_heat_q <= 8'd6;
			heat_inc_q    <= 8'd4;
		end else if (cfg_wr) begin
			case (reg_idx)
				phga_pkg::REG_IGNITION_TIME: ignition_q    <= pwdata[15:0];
				phga_pkg::REG_TOTAL_TIME:    total_q       <= pwdata[15:0];
				phga_pkg::REG_SPARKS:        sparks_q      <= pwdata[3:0];
				phga_pkg::REG_SPREAD_MIN:    spread_min_q  <= pwdata[7:0];
				phga_pkg::REG_SPREAD_HEAT:   spread_heat_q <= pwdata[7:0];
				phga_pkg::REG_HEAT_INC:      heat_inc_q    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (reg_idx)
			phga_pkg::REG_IGNITION_TIME: prdata = {16'd0, ignition_q};
			phga_pkg::REG_TOTAL_TIME:    prdata = {16'd0, total_q};
			phga_pkg::REG_SPARKS:        prdata = {28'd0, sparks_q};
			phga_pkg::REG_SPREAD_MIN:    prdata = {24'd0, spread_min_q};
			phga_pkg::REG_SPREAD_HEAT:   prdata = {24'd0, spread_heat_q};
			phga_pkg::REG_HEAT_INC:      prdata = {24'd0, heat_inc_q};
			default:                     prdata = '0;
		endcase
	end

	// Checks
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("grid written while idle");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken before the first finished");

	a_heat_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HT_CK && ram_we) |-> (ram_wdata >= ram_rdata))
		else $error("heating lowered a cell");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> (m_tvalid_q && $stable(m_tdata_q)))
		else $error("pending result lost");

endmodule

// ===== sv/phga_ram.sv =====
// ----------------------------------------------------------------------------
// phga_ram
// Generic single-port RAM, one read with an optional write to the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
module phga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
